/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle, off during reset
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// implication checked in the next cycle, off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// implication checked in the next cycle, also across reset
`define ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

/* design/bsc_pkg.sv */
// ----------------------------------------------------------------------------
// bsc_pkg
// Types and constants of the barometric sensor compensation core.
// ----------------------------------------------------------------------------
package bsc_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESS_SENS  = 3'd0,
        CFG_PRESS_OFS   = 3'd1,
        CFG_SENS_TCO    = 3'd2,
        CFG_OFS_TCO     = 3'd3,
        CFG_REF_TEMP    = 3'd4,
        CFG_TEMP_SLOPE  = 3'd5
    } t_cfg_idx;

    localparam int CAL_W   = 16;
    localparam int RAW_W   = 24;
    localparam int TOUT_W  = 19;
    localparam int POUT_W  = 32;

    // pipeline depth
    localparam int NSTG    = 10;

    // temperature thresholds in 0.01 degC
    localparam int TEMP_REF_CENTI = 2000;
    localparam int TEMP_LOW_CENTI = -1500;
    localparam int LOW_GAP        = TEMP_REF_CENTI - TEMP_LOW_CENTI;

    // shift amounts
    localparam int REF_SHIFT   = 8;
    localparam int TEMP_SHIFT  = 23;
    localparam int T2_SHIFT    = 31;
    localparam int OFS_SHIFT   = 16;
    localparam int SENS_SHIFT  = 15;
    localparam int OFS_T_SHIFT = 7;
    localparam int SENS_T_SHIFT = 8;
    localparam int PROD_SHIFT  = 21;
    localparam int P_SHIFT     = 15;

    // second order coefficients
    localparam int K_OFF_A  = 5;
    localparam int K_OFF_B  = 7;
    localparam int K_SENS_B = 11;

    // datapath widths
    localparam int DT_W    = RAW_W + 1;
    localparam int DTC_W   = DT_W + CAL_W + 1;
    localparam int DTSQ_W  = 2 * DT_W;
    localparam int TA_W    = DTC_W - TEMP_SHIFT;
    localparam int T2_W    = DTSQ_W - 1 - T2_SHIFT;
    localparam int SQ_W    = 36;
    localparam int CORR_W  = 40;
    localparam int OFF_W   = 42;
    localparam int SPLIT   = 24;
    localparam int PL_W    = RAW_W + SPLIT;
    localparam int PH_W    = OFF_W - SPLIT + RAW_W + 1;
    localparam int FULL_W  = PH_W + SPLIT;
    localparam int PSH_W   = FULL_W - PROD_SHIFT;
    localparam int X_W     = 48;
    localparam int PS_W    = X_W - P_SHIFT;

endpackage

/* design/baro_sensor_compensation_core.sv */
// ----------------------------------------------------------------------------
// baro_sensor_compensation_core
// Second order pressure and temperature compensation of a barometric sensor.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one raw pressure and one raw
//   temperature conversion; a transfer happens when valid is high and stall
//   is low. Output channel: o_out_valid / i_out_stall carry compensated
//   temperature (0.01 degC) and pressure (Pa).
//   Configuration: i_cfg_valid / o_cfg_ready write the six calibration words
//   by index; indexes above five are dropped. Write only while idle.
//   Pipeline: ten register stages from the input transfer to o_out_valid.
//   Throughput: one item per cycle while o_in_stall is low; the widest step
//   is the 25 x 25 bit square of dT.
//   Stall: each stage holds when full and the stage after it cannot move, so
//   empty stages keep filling while the output waits; o_in_stall rises only
//   when all ten stages hold items.
//   Reset: synchronous, active low; clears all stage valid bits and sets the
//   calibration words to zero.
// ----------------------------------------------------------------------------
module baro_sensor_compensation_core
    import bsc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CAL_W-1:0]          i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [RAW_W-1:0]          i_raw_pressure,
    input  logic [RAW_W-1:0]          i_raw_temperature,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [TOUT_W-1:0]  o_temp_centi,
    output logic signed [POUT_W-1:0]  o_pressure_pa
);

    // calibration words
    logic [CAL_W-1:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PRESS_SENS: r_c1 <= i_cfg_data;
                CFG_PRESS_OFS:  r_c2 <= i_cfg_data;
                CFG_SENS_TCO:   r_c3 <= i_cfg_data;
                CFG_OFS_TCO:    r_c4 <= i_cfg_data;
                CFG_REF_TEMP:   r_c5 <= i_cfg_data;
                CFG_TEMP_SLOPE: r_c6 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage control
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_rdy;
    logic [NSTG-1:0] w_vin;

    always_comb begin
        w_rdy[NSTG-1] = !r_vld[NSTG-1] || !i_out_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign w_vin      = {r_vld[NSTG-2:0], i_in_valid};
    assign o_in_stall = !w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    // stage 0: temperature difference
    logic [RAW_W-1:0]         r_d1 [0:5];
    logic signed [DT_W-1:0]   r_dt;
    logic signed [DT_W-1:0]   n_dt;

    assign n_dt = $signed({1'b0, i_raw_temperature})
                - $signed({1'b0, r_c5, {REF_SHIFT{1'b0}}});

    // stage 1: products of dT
    logic signed [DTC_W-1:0]  r_dtc6, r_c4dt, r_c3dt;
    logic signed [DTSQ_W-1:0] r_dtsq;

    // stage 2: first order terms
    logic signed [TA_W-1:0]   r_a, r_b;
    logic signed [TA_W-1:0]   n_a;
    logic                     r_lo2, r_vlo2, r_lo3, r_vlo3;
    logic [T2_W-1:0]          r_t2_2, r_t2_3;
    logic signed [TA_W-1:0]   r_temp2, r_temp3;
    logic signed [OFF_W-1:0]  r_off1 [2:4];
    logic signed [OFF_W-1:0]  r_sens1 [2:4];

    assign n_a = r_dtc6[DTC_W-1:TEMP_SHIFT];

    // stage 3: squares
    logic signed [2*TA_W-1:0] w_asq_full, w_bsq_full;
    logic [SQ_W-1:0]          r_asq, r_bsq;

    assign w_asq_full = r_a * r_a;
    assign w_bsq_full = r_b * r_b;

    // stage 4: second order corrections
    logic [CORR_W-1:0]        w_a5, w_b7, w_b11;
    logic [CORR_W-1:0]        n_off2, n_sens2;
    logic [CORR_W-1:0]        r_off2, r_sens2;
    logic signed [TOUT_W-1:0] r_tout [4:9];

    assign w_a5  = CORR_W'(r_asq) * CORR_W'(K_OFF_A);
    assign w_b7  = CORR_W'(r_bsq) * CORR_W'(K_OFF_B);
    assign w_b11 = CORR_W'(r_bsq[SQ_W-1:1]) * CORR_W'(K_SENS_B);

    always_comb begin
        n_off2  = '0;
        n_sens2 = '0;
        if (r_lo3) begin
            n_off2  = w_a5 >> 1;
            n_sens2 = w_a5 >> 2;
            if (r_vlo3) begin
                n_off2  = n_off2 + w_b7;
                n_sens2 = n_sens2 + w_b11;
            end
        end
    end

    // stage 5: offset and sensitivity
    logic signed [OFF_W-1:0]  r_off [5:7];
    logic signed [OFF_W-1:0]  r_sens;

    // stage 6: split pressure product
    logic [PL_W-1:0]          r_pl;
    logic signed [PH_W-1:0]   r_ph;

    // stage 7: product sum
    logic signed [FULL_W-1:0] w_full;
    logic signed [PSH_W-1:0]  r_psh;

    assign w_full = $signed({r_ph, {SPLIT{1'b0}}})
                  + $signed({{(FULL_W-PL_W){1'b0}}, r_pl});

    // stage 8: subtract offset
    logic signed [X_W-1:0]    r_x;

    // stage 9: scale and saturate
    logic signed [PS_W-1:0]   w_ps;
    logic signed [POUT_W-1:0] n_p;
    logic signed [POUT_W-1:0] r_p;

    assign w_ps = r_x[X_W-1:P_SHIFT];

    always_comb begin
        if (w_ps > $signed(PS_W'({1'b0, {(POUT_W-1){1'b1}}}))) begin
            n_p = {1'b0, {(POUT_W-1){1'b1}}};
        end else if (w_ps < $signed({{(PS_W-POUT_W+1){1'b1}}, {(POUT_W-1){1'b0}}})) begin
            n_p = {1'b1, {(POUT_W-1){1'b0}}};
        end else begin
            n_p = w_ps[POUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_d1[0] <= i_raw_pressure;
            r_dt    <= n_dt;
        end
        if (w_rdy[1]) begin
            r_d1[1] <= r_d1[0];
            r_dtc6  <= r_dt * $signed({1'b0, r_c6});
            r_c4dt  <= r_dt * $signed({1'b0, r_c4});
            r_c3dt  <= r_dt * $signed({1'b0, r_c3});
            r_dtsq  <= r_dt * r_dt;
        end
        if (w_rdy[2]) begin
            r_d1[2]    <= r_d1[1];
            r_a        <= n_a;
            r_b        <= n_a + TA_W'(LOW_GAP);
            r_lo2      <= n_a < 0;
            r_vlo2     <= n_a < -TA_W'(LOW_GAP);
            r_t2_2     <= r_dtsq[DTSQ_W-2:T2_SHIFT];
            r_temp2    <= n_a + TA_W'(TEMP_REF_CENTI);
            r_off1[2]  <= $signed({{(OFF_W-CAL_W-OFS_SHIFT){1'b0}}, r_c2, {OFS_SHIFT{1'b0}}})
                        + OFF_W'(r_c4dt >>> OFS_T_SHIFT);
            r_sens1[2] <= $signed({{(OFF_W-CAL_W-SENS_SHIFT){1'b0}}, r_c1,
                                   {SENS_SHIFT{1'b0}}})
                        + OFF_W'(r_c3dt >>> SENS_T_SHIFT);
        end
        if (w_rdy[3]) begin
            r_d1[3]    <= r_d1[2];
            r_asq      <= w_asq_full[SQ_W-1:0];
            r_bsq      <= w_bsq_full[SQ_W-1:0];
            r_lo3      <= r_lo2;
            r_vlo3     <= r_vlo2;
            r_t2_3     <= r_t2_2;
            r_temp3    <= r_temp2;
            r_off1[3]  <= r_off1[2];
            r_sens1[3] <= r_sens1[2];
        end
        if (w_rdy[4]) begin
            r_d1[4]    <= r_d1[3];
            r_off2     <= n_off2;
            r_sens2    <= n_sens2;
            r_tout[4]  <= r_lo3 ? r_temp3 - $signed({1'b0, r_t2_3}) : r_temp3;
            r_off1[4]  <= r_off1[3];
            r_sens1[4] <= r_sens1[3];
        end
        if (w_rdy[5]) begin
            r_d1[5]   <= r_d1[4];
            r_off[5]  <= r_off1[4] - $signed({{(OFF_W-CORR_W){1'b0}}, r_off2});
            r_sens    <= r_sens1[4] - $signed({{(OFF_W-CORR_W){1'b0}}, r_sens2});
            r_tout[5] <= r_tout[4];
        end
        if (w_rdy[6]) begin
            r_pl      <= r_d1[5] * r_sens[SPLIT-1:0];
            r_ph      <= $signed(r_sens[OFF_W-1:SPLIT]) * $signed({1'b0, r_d1[5]});
            r_off[6]  <= r_off[5];
            r_tout[6] <= r_tout[5];
        end
        if (w_rdy[7]) begin
            r_psh     <= w_full[FULL_W-1:PROD_SHIFT];
            r_off[7]  <= r_off[6];
            r_tout[7] <= r_tout[6];
        end
        if (w_rdy[8]) begin
            r_x       <= $signed({{(X_W-PSH_W){r_psh[PSH_W-1]}}, r_psh})
                       - $signed({{(X_W-OFF_W){r_off[7][OFF_W-1]}}, r_off[7]});
            r_tout[8] <= r_tout[7];
        end
        if (w_rdy[9]) begin
            r_p       <= n_p;
            r_tout[9] <= r_tout[8];
        end
    end

    assign o_out_valid   = r_vld[NSTG-1];
    assign o_temp_centi  = r_tout[9];
    assign o_pressure_pa = r_p;

endmodule

/* design/bsc_checker.sv */
// ----------------------------------------------------------------------------
// bsc_checker
// Port level checks of the barometric sensor compensation core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsc_checker
    import bsc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      o_in_stall,
    input  logic                      o_out_valid,
    input  logic                      i_out_stall,
    input  logic signed [TOUT_W-1:0]  o_temp_centi,
    input  logic signed [POUT_W-1:0]  o_pressure_pa
);

    logic                     w_out_wait;
    logic [TOUT_W+POUT_W-1:0] w_result;

    assign w_out_wait = o_out_valid && i_out_stall;
    assign w_result   = {o_temp_centi, o_pressure_pa};

    // a stalled result holds until its transfer
    `ASSERT_NEXT(a_out_hold, w_out_wait, o_out_valid && $stable(w_result), "held result changed")

    // input side backs up only behind a waiting result
    `ASSERT_SAME(a_in_stall_cause, o_in_stall, w_out_wait, "input stalled with free output")

    // reset empties the pipeline
    `ASSERT_NEXT_ALWAYS(a_rst_empty, !i_rst_n, !o_out_valid, "result valid after reset")

endmodule

bind baro_sensor_compensation_core bsc_checker u_bsc_checker (.*);

/* sim/bsc_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bsc_result_checker
// Watches the calibration, sample and result channels of the compensation
// core, keeps its own copy of the calibration words, computes the expected
// temperature and pressure for every sample transfer and compares each result
// transfer against the oldest expected reading.
// ----------------------------------------------------------------------------
module bsc_result_checker
    import bsc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CAL_W-1:0]          i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [RAW_W-1:0]          i_raw_pressure,
    input  logic [RAW_W-1:0]          i_raw_temperature,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic signed [TOUT_W-1:0]  i_temp_centi,
    input  logic signed [POUT_W-1:0]  i_pressure_pa,
    output int                        o_mismatch_count,
    output int                        o_readings_owed
);

    typedef logic signed [63:0] t_wide;

    localparam t_wide REF_CENTI     = 2000;
    localparam t_wide COLD_CENTI    = -1500;
    localparam t_wide PRESS_MAX     = 64'sd2147483647;
    localparam t_wide PRESS_MIN     = -64'sd2147483648;
    localparam t_wide OFF2_GAIN     = 5;
    localparam t_wide OFF2_COLD     = 7;
    localparam t_wide SENS2_COLD    = 11;

    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic [RAW_W-1:0]         d2;
        logic signed [TOUT_W-1:0] temp_centi;
        logic signed [POUT_W-1:0] pressure_pa;
    } t_reading;

    logic [CAL_W-1:0] cal_press_sens;
    logic [CAL_W-1:0] cal_press_ofs;
    logic [CAL_W-1:0] cal_sens_tco;
    logic [CAL_W-1:0] cal_ofs_tco;
    logic [CAL_W-1:0] cal_ref_temp;
    logic [CAL_W-1:0] cal_temp_slope;

    t_reading expected_readings[$];
    t_reading want;
    int       mismatch_count = 0;

    function automatic t_reading compensate_reading(input logic [RAW_W-1:0] d1,
                                                    input logic [RAW_W-1:0] d2);
        t_wide    dt;
        t_wide    temp;
        t_wide    t2;
        t_wide    off2;
        t_wide    sens2;
        t_wide    dev;
        t_wide    dev_cold;
        t_wide    offset;
        t_wide    sens;
        t_wide    press;
        t_wide    temp_out;
        t_reading r;
        dt    = $signed({40'd0, d2}) - ($signed({48'd0, cal_ref_temp}) <<< 8);
        temp  = REF_CENTI + ((dt * $signed({48'd0, cal_temp_slope})) >>> 23);
        t2    = 0;
        off2  = 0;
        sens2 = 0;
        if (temp < REF_CENTI) begin
            dev   = temp - REF_CENTI;
            t2    = (dt * dt) >>> 31;
            off2  = (OFF2_GAIN * dev * dev) >>> 1;
            sens2 = (OFF2_GAIN * dev * dev) >>> 2;
            if (temp < COLD_CENTI) begin
                dev_cold = temp - COLD_CENTI;
                off2  = off2 + OFF2_COLD * dev_cold * dev_cold;
                sens2 = sens2 + SENS2_COLD * ((dev_cold * dev_cold) >>> 1);
            end
        end
        offset = ($signed({48'd0, cal_press_ofs}) <<< 16)
               + (($signed({48'd0, cal_ofs_tco}) * dt) >>> 7) - off2;
        sens   = ($signed({48'd0, cal_press_sens}) <<< 15)
               + (($signed({48'd0, cal_sens_tco}) * dt) >>> 8) - sens2;
        press  = ((($signed({40'd0, d1}) * sens) >>> 21) - offset) >>> 15;
        if (press > PRESS_MAX)
            press = PRESS_MAX;
        if (press < PRESS_MIN)
            press = PRESS_MIN;
        temp_out      = temp - t2;
        r.d1          = d1;
        r.d2          = d2;
        r.temp_centi  = temp_out[TOUT_W-1:0];
        r.pressure_pa = press[POUT_W-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cal_press_sens = '0;
            cal_press_ofs  = '0;
            cal_sens_tco   = '0;
            cal_ofs_tco    = '0;
            cal_ref_temp   = '0;
            cal_temp_slope = '0;
            expected_readings.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PRESS_SENS: cal_press_sens = i_cfg_data;
                    CFG_PRESS_OFS:  cal_press_ofs  = i_cfg_data;
                    CFG_SENS_TCO:   cal_sens_tco   = i_cfg_data;
                    CFG_OFS_TCO:    cal_ofs_tco    = i_cfg_data;
                    CFG_REF_TEMP:   cal_ref_temp   = i_cfg_data;
                    CFG_TEMP_SLOPE: cal_temp_slope = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_readings.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result temp %0d pressure %0d",
                                            i_temp_centi, i_pressure_pa));
                end else begin
                    want = expected_readings.pop_front();
                    if (i_temp_centi !== want.temp_centi)
                        flag_mismatch($sformatf("temp_centi d1=%0d d2=%0d got %0d want %0d",
                                                want.d1, want.d2, i_temp_centi,
                                                want.temp_centi));
                    if (i_pressure_pa !== want.pressure_pa)
                        flag_mismatch($sformatf("pressure_pa d1=%0d d2=%0d got %0d want %0d",
                                                want.d1, want.d2, i_pressure_pa,
                                                want.pressure_pa));
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_readings.push_back(compensate_reading(i_raw_pressure,
                                                               i_raw_temperature));
        end
        o_mismatch_count <= mismatch_count;
        o_readings_owed  <= expected_readings.size();
    end

endmodule

/* sim/tb_baro_sensor_compensation_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_baro_sensor_compensation_core
// Drives calibration words and raw sample pairs into the compensation core
// with random gaps and output stalls: a directed set of boundary readings
// under fixed calibrations, then random phases under random calibrations.
// The checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_baro_sensor_compensation_core;
    import bsc_pkg::*;

    localparam int                   RANDOM_PHASES   = 8;
    localparam int                   PHASE_ITEMS     = 100;
    localparam int                   DRAIN_LIMIT     = 20000;
    localparam logic [RAW_W-1:0]     RAW_MAX         = {RAW_W{1'b1}};
    localparam logic [RAW_W-1:0]     D1_TYPICAL      = 24'd9085466;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI   = 3'd7;

    logic                     i_clk             = 1'b0;
    logic                     i_rst_n           = 1'b0;
    logic                     i_cfg_valid       = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index       = '0;
    logic [CAL_W-1:0]         i_cfg_data        = '0;
    logic                     i_in_valid        = 1'b0;
    logic [RAW_W-1:0]         i_raw_pressure    = '0;
    logic [RAW_W-1:0]         i_raw_temperature = '0;
    logic                     i_out_stall       = 1'b0;
    logic                     o_cfg_ready;
    logic                     o_in_stall;
    logic                     o_out_valid;
    logic signed [TOUT_W-1:0] o_temp_centi;
    logic signed [POUT_W-1:0] o_pressure_pa;

    int                       mismatch_count;
    int                       readings_owed;
    bit                       quiet = 1'b0;
    logic [CAL_W-1:0]         cal_words [6];

    baro_sensor_compensation_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_temp_centi      (o_temp_centi),
        .o_pressure_pa     (o_pressure_pa)
    );

    bsc_result_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_temp_centi      (o_temp_centi),
        .i_pressure_pa     (o_pressure_pa),
        .o_mismatch_count  (mismatch_count),
        .o_readings_owed   (readings_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("baro_sensor_compensation_core: mismatch");
        $finish;
    end

    initial begin
        @(posedge i_clk);
        forever begin
            if (quiet) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else if ($urandom_range(0, 2) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    task automatic write_cal_word(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CAL_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic program_calibration(input bit poke_unused);
        for (int i = CFG_PRESS_SENS; i <= CFG_TEMP_SLOPE; i++)
            write_cal_word(CFG_IDX_W'(i), cal_words[i]);
        if (poke_unused) begin
            write_cal_word(CFG_UNUSED_LO, CAL_W'($urandom));
            write_cal_word(CFG_UNUSED_HI, CAL_W'($urandom));
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain_readings();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (readings_owed != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    task automatic send_sample(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
        i_in_valid        <= 1'b1;
        i_raw_pressure    <= d1;
        i_raw_temperature <= d2;
        do @(posedge i_clk); while (o_in_stall);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic send_random_sample();
        logic signed [63:0] tv;
        logic [RAW_W-1:0]   d1;
        logic [RAW_W-1:0]   d2;
        int                 spread;
        case ($urandom_range(0, 9))
            0, 1, 2: d2 = RAW_W'($urandom);
            default: begin
                spread = 1 << $urandom_range(2, 23);
                tv = $signed({48'd0, cal_words[CFG_REF_TEMP]}) * 256
                   + $signed({32'd0, $urandom_range(0, 2 * spread)})
                   - $signed({32'd0, spread});
                if (tv < 0)
                    tv = 0;
                if (tv > $signed({40'd0, RAW_MAX}))
                    tv = $signed({40'd0, RAW_MAX});
                d2 = tv[RAW_W-1:0];
            end
        endcase
        case ($urandom_range(0, 9))
            0:       d1 = RAW_MAX;
            1:       d1 = '0;
            2, 3, 4: d1 = RAW_W'($urandom_range(7000000, 11000000));
            default: d1 = RAW_W'($urandom);
        endcase
        send_sample(d1, d2);
    endtask

    task automatic randomize_calibration();
        for (int i = CFG_PRESS_SENS; i <= CFG_TEMP_SLOPE; i++) begin
            case ($urandom_range(0, 7))
                0:       cal_words[i] = '0;
                1:       cal_words[i] = {CAL_W{1'b1}};
                default: cal_words[i] = CAL_W'($urandom);
            endcase
        end
    endtask

    initial begin
        int drain_at;
        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // uncalibrated core
        send_sample('0, '0);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample(RAW_MAX, '0);
        drain_readings();

        // slope of 2^15 puts the 20.00 and -15.00 degree edges on exact codes
        cal_words = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd40000, 16'd32768};
        program_calibration(1'b1);
        send_sample(D1_TYPICAL, 24'd10240000);
        send_sample('0, 24'd10239999);
        send_sample(RAW_MAX, 24'd10112000);
        send_sample(D1_TYPICAL, 24'd9344000);
        send_sample(D1_TYPICAL, 24'd9343744);
        send_sample(RAW_MAX, '0);
        send_sample(RAW_MAX, RAW_MAX);
        drain_readings();

        cal_words = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
        program_calibration(1'b0);
        send_sample(D1_TYPICAL, 24'd8569150);
        send_sample('0, 24'd8569150);
        send_sample(RAW_MAX, 24'd8569150);
        drain_readings();

        cal_words = '{default: {CAL_W{1'b1}}};
        program_calibration(1'b1);
        send_sample(RAW_MAX, '0);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample('0, '0);
        send_sample(D1_TYPICAL, 24'd16776960);
        drain_readings();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            randomize_calibration();
            program_calibration($urandom_range(0, 1));
            quiet = (phase == RANDOM_PHASES - 1);
            drain_at = $urandom_range(10, PHASE_ITEMS - 10);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == drain_at && !quiet)
                    drain_readings();
                send_random_sample();
            end
            drain_readings();
        end

        repeat (NSTG + 4) @(posedge i_clk);
        if (mismatch_count == 0 && readings_owed == 0) begin
            $display("baro_sensor_compensation_core: match");
        end else begin
            $display("baro_sensor_compensation_core: mismatch");
        end
        $finish;
    end

endmodule
